[rtl/vertex_dedup_table_with_decay_assert.svh]
// Assertion macros shared by the checker of the point table.
`ifndef VERTEX_DEDUP_TABLE_WITH_DECAY_ASSERT_SVH
`define VERTEX_DEDUP_TABLE_WITH_DECAY_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define VDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define VDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/vdt_pkg.sv]
package vdt_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned SEL_W        = 10;
  localparam int unsigned COUNT_OUT_W  = 11;
  localparam int signed   RATE_LIMIT   = 127;

  typedef enum logic [2:0] {
    OP_FIND       = 3'd0,
    OP_TICK       = 3'd1,
    OP_KICK       = 3'd2,
    OP_SET_TAG    = 3'd3,
    OP_READ       = 3'd4,
    OP_CLEAR_TAGS = 3'd5,
    OP_EMPTY      = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    F_FIND,
    F_INSERT,
    F_TICK,
    F_CLEAR_TAG,
    F_KICK,
    F_SET_TAG,
    F_READ
  } alu_func_e;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_EX,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  z;
    logic [10:0] spin;
    logic [7:0]  rate;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic [SEL_W-1:0]       point_index;
    logic                   found;
    logic                   table_full;
    logic                   bad_index;
    logic [7:0]             rd_x;
    logic [7:0]             rd_y;
    logic [7:0]             rd_z;
    logic [10:0]            rd_spin;
    logic [7:0]             rd_rate;
    logic [15:0]            rd_tag;
    logic [COUNT_OUT_W-1:0] point_count;
  } res_t;

  function automatic res_t show_point(entry_t e, logic [SEL_W-1:0] idx,
                                      logic [COUNT_OUT_W-1:0] cnt);
    res_t r;
    r             = '0;
    r.point_index = idx;
    r.rd_x        = e.x;
    r.rd_y        = e.y;
    r.rd_z        = e.z;
    r.rd_spin     = e.spin;
    r.rd_rate     = e.rate;
    r.rd_tag      = e.tag;
    r.point_count = cnt;
    return r;
  endfunction

endpackage

[rtl/vdt_mem.sv]
module vdt_mem #(
  parameter int unsigned DEPTH = vdt_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  vdt_pkg::entry_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output vdt_pkg::entry_t rdata_o
);

  vdt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/vdt_alu.sv]
module vdt_alu (
  input  vdt_pkg::alu_func_e func_i,
  input  vdt_pkg::entry_t    entry_i,
  input  logic [7:0]         key_x_i,
  input  logic [7:0]         key_y_i,
  input  logic [7:0]         key_z_i,
  input  logic [15:0]        push_i,
  input  logic [15:0]        tag_i,
  output vdt_pkg::entry_t    entry_o,
  output logic               hit_o
);

  logic signed [7:0]  rate;
  logic signed [16:0] kick_sum;

  assign rate     = $signed(entry_i.rate);
  assign kick_sum = 17'(rate) + 17'($signed(push_i));
  assign hit_o    = ({entry_i.x, entry_i.y, entry_i.z} == {key_x_i, key_y_i, key_z_i});

  always_comb begin
    entry_o = entry_i;
    case (func_i)
      vdt_pkg::F_INSERT: begin
        entry_o.x    = key_x_i;
        entry_o.y    = key_y_i;
        entry_o.z    = key_z_i;
        entry_o.spin = '0;
        entry_o.rate = '0;
      end
      vdt_pkg::F_TICK: begin
        // Spin wraps modulo 2048; rate decays one step toward zero.
        entry_o.spin = entry_i.spin + 11'(rate);
        if (rate > 8'sd0) begin
          entry_o.rate = entry_i.rate - 8'd1;
        end else if (rate < 8'sd0) begin
          entry_o.rate = entry_i.rate + 8'd1;
        end
      end
      vdt_pkg::F_CLEAR_TAG: entry_o.tag = '0;
      vdt_pkg::F_KICK: begin
        if (kick_sum > 17'(vdt_pkg::RATE_LIMIT)) begin
          entry_o.rate = 8'(vdt_pkg::RATE_LIMIT);
        end else if (kick_sum < -17'(vdt_pkg::RATE_LIMIT)) begin
          entry_o.rate = 8'(-vdt_pkg::RATE_LIMIT);
        end else begin
          entry_o.rate = kick_sum[7:0];
        end
      end
      vdt_pkg::F_SET_TAG: entry_o.tag = tag_i;
      default: ;
    endcase
  end

endmodule

[rtl/vertex_dedup_table_with_decay.sv]
// Channel   Dir  Handshake                     tuser               tdata
// s_axis    in   s_axis_tvalid/s_axis_tready   op                  key, point_sel, push, tag
// m_axis    out  m_axis_tvalid/m_axis_tready   flags               point index, fields, count
//
// find_or_insert walks down from the newest point and stops on a hit; on a miss with room,
// or on an empty table, it reads and writes the free entry. tick and clear_tags walk every
// point, or none with no points. kick, set_tag and read_point touch one entry, none on a bad
// index; the rest none. The walk reads one entry a cycle via the single memory read port.
// After reset a clearing pass over all CAPACITY entries zeroes the memory; no beat is taken.
// A stalled m_axis side holds one result in the output register while the next beat runs.
module vertex_dedup_table_with_decay #(
  parameter int unsigned CAPACITY = vdt_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tuser: op[2:0]
  input  logic [2:0]  s_axis_tuser,
  // tdata: key_x[7:0], key_y[15:8], key_z[23:16], point_sel[33:24],
  //        push_req[49:34], tag_value[65:50], zero fill[71:66]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tuser: found[0], table_full[1], bad_index[2]
  output logic [2:0]  m_axis_tuser,
  // tdata: point_index[9:0], rd_x[17:10], rd_y[25:18], rd_z[33:26],
  //        rd_spin[44:34], rd_rate[52:45], rd_tag[68:53], point_count[79:69]
  output logic [79:0] m_axis_tdata
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > vdt_pkg::SEL_W) ? CW : vdt_pkg::SEL_W;

  vdt_pkg::state_e    state_q, state_d;
  vdt_pkg::op_e       op_q, in_op;
  vdt_pkg::alu_func_e alu_func;
  logic [AW-1:0]      ptr_q, ptr_d, ptr_next;
  logic [CW-1:0]      count_q, count_d;
  logic               ins_q, ins_d;
  vdt_pkg::res_t      res_q, res_d, out_q;
  logic               out_valid_q, out_valid_d, out_load;
  logic [7:0]         key_x_q, key_y_q, key_z_q;
  logic [15:0]        push_q, tag_q;
  logic [vdt_pkg::SEL_W-1:0] in_sel;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  vdt_pkg::entry_t mem_wdata, mem_rdata, alu_out;
  logic            hit;

  logic in_acc, clr_last, down_last, up_last, full, cnt_zero, sel_bad;

  assign in_op  = vdt_pkg::op_e'(s_axis_tuser);
  assign in_sel = s_axis_tdata[33:24];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign clr_last  = (ptr_q == AW'(CAPACITY - 1));
  assign down_last = (ptr_q == '0);
  assign up_last   = (ptr_q == AW'(count_q - 1'b1));
  assign full      = (count_q == CW'(CAPACITY));
  assign cnt_zero  = (count_q == '0);
  assign sel_bad   = (CMPW'(in_sel) >= CMPW'(count_q));

  vdt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    if (ins_q) begin
      alu_func = vdt_pkg::F_INSERT;
    end else begin
      case (op_q)
        vdt_pkg::OP_FIND:       alu_func = vdt_pkg::F_FIND;
        vdt_pkg::OP_TICK:       alu_func = vdt_pkg::F_TICK;
        vdt_pkg::OP_KICK:       alu_func = vdt_pkg::F_KICK;
        vdt_pkg::OP_SET_TAG:    alu_func = vdt_pkg::F_SET_TAG;
        vdt_pkg::OP_CLEAR_TAGS: alu_func = vdt_pkg::F_CLEAR_TAG;
        default:                alu_func = vdt_pkg::F_READ;
      endcase
    end
  end

  vdt_alu u_alu (
    .func_i  (alu_func),
    .entry_i (mem_rdata),
    .key_x_i (key_x_q),
    .key_y_i (key_y_q),
    .key_z_i (key_z_q),
    .push_i  (push_q),
    .tag_i   (tag_q),
    .entry_o (alu_out),
    .hit_o   (hit)
  );

  // Lookups walk from the newest point down; sweeps walk up from entry zero.
  always_comb begin
    if (!ins_q && op_q == vdt_pkg::OP_FIND) begin
      ptr_next = ptr_q - 1'b1;
    end else if (!ins_q && (op_q == vdt_pkg::OP_TICK || op_q == vdt_pkg::OP_CLEAR_TAGS)) begin
      ptr_next = ptr_q + 1'b1;
    end else begin
      ptr_next = ptr_q;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      vdt_pkg::S_CLR: begin
        if (clr_last) state_d = vdt_pkg::S_IDLE;
      end
      vdt_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            vdt_pkg::OP_FIND: state_d = vdt_pkg::S_RD;
            vdt_pkg::OP_TICK, vdt_pkg::OP_CLEAR_TAGS:
              state_d = cnt_zero ? vdt_pkg::S_DONE : vdt_pkg::S_RD;
            vdt_pkg::OP_KICK, vdt_pkg::OP_SET_TAG, vdt_pkg::OP_READ:
              state_d = sel_bad ? vdt_pkg::S_DONE : vdt_pkg::S_RD;
            default: state_d = vdt_pkg::S_DONE;
          endcase
        end
      end
      vdt_pkg::S_RD: state_d = vdt_pkg::S_EX;
      vdt_pkg::S_EX: begin
        if (ins_q) begin
          state_d = vdt_pkg::S_DONE;
        end else begin
          case (op_q)
            vdt_pkg::OP_FIND: begin
              if (hit) begin
                state_d = vdt_pkg::S_DONE;
              end else if (down_last) begin
                state_d = full ? vdt_pkg::S_DONE : vdt_pkg::S_RD;
              end
            end
            vdt_pkg::OP_TICK, vdt_pkg::OP_CLEAR_TAGS: begin
              if (up_last) state_d = vdt_pkg::S_DONE;
            end
            default: state_d = vdt_pkg::S_DONE;
          endcase
        end
      end
      vdt_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = vdt_pkg::S_IDLE;
      end
      default: state_d = vdt_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = alu_out;
    mem_raddr = ptr_q;
    ptr_d     = ptr_q;
    ins_d     = ins_q;
    count_d   = count_q;
    res_d     = res_q;
    out_load  = 1'b0;
    case (state_q)
      vdt_pkg::S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        ptr_d     = clr_last ? '0 : ptr_q + 1'b1;
      end
      vdt_pkg::S_IDLE: begin
        if (in_acc) begin
          res_d             = '0;
          res_d.point_count = vdt_pkg::COUNT_OUT_W'(count_q);
          ins_d             = 1'b0;
          case (in_op)
            vdt_pkg::OP_FIND: begin
              if (cnt_zero) begin
                ins_d = 1'b1;
                ptr_d = '0;
              end else begin
                ptr_d = AW'(count_q - 1'b1);
              end
            end
            vdt_pkg::OP_TICK, vdt_pkg::OP_CLEAR_TAGS: ptr_d = '0;
            vdt_pkg::OP_KICK, vdt_pkg::OP_SET_TAG, vdt_pkg::OP_READ: begin
              if (sel_bad) begin
                res_d.point_index = in_sel;
                res_d.bad_index   = 1'b1;
              end else begin
                ptr_d = AW'(in_sel);
              end
            end
            vdt_pkg::OP_EMPTY: begin
              count_d           = '0;
              res_d.point_count = '0;
            end
            default: ;
          endcase
        end
      end
      vdt_pkg::S_RD: ;
      vdt_pkg::S_EX: begin
        mem_raddr = ptr_next;
        ptr_d     = ptr_next;
        if (ins_q) begin
          mem_we  = 1'b1;
          count_d = count_q + 1'b1;
          res_d   = vdt_pkg::show_point(alu_out, vdt_pkg::SEL_W'(ptr_q),
                                        vdt_pkg::COUNT_OUT_W'(count_q + 1'b1));
        end else begin
          case (op_q)
            vdt_pkg::OP_FIND: begin
              if (hit) begin
                res_d       = vdt_pkg::show_point(mem_rdata, vdt_pkg::SEL_W'(ptr_q),
                                                  vdt_pkg::COUNT_OUT_W'(count_q));
                res_d.found = 1'b1;
              end else if (down_last) begin
                if (full) begin
                  res_d.table_full = 1'b1;
                end else begin
                  // Miss: come back through a read of the free entry to keep its tag.
                  ins_d = 1'b1;
                  ptr_d = AW'(count_q);
                end
              end
            end
            vdt_pkg::OP_TICK, vdt_pkg::OP_CLEAR_TAGS: mem_we = 1'b1;
            vdt_pkg::OP_KICK, vdt_pkg::OP_SET_TAG: begin
              mem_we = 1'b1;
              res_d  = vdt_pkg::show_point(alu_out, vdt_pkg::SEL_W'(ptr_q),
                                           vdt_pkg::COUNT_OUT_W'(count_q));
            end
            vdt_pkg::OP_READ: begin
              res_d = vdt_pkg::show_point(mem_rdata, vdt_pkg::SEL_W'(ptr_q),
                                          vdt_pkg::COUNT_OUT_W'(count_q));
            end
            default: ;
          endcase
        end
      end
      vdt_pkg::S_DONE: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vdt_pkg::S_CLR;
      ptr_q       <= '0;
      count_q     <= '0;
      ins_q       <= 1'b0;
      op_q        <= vdt_pkg::OP_READ;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      count_q     <= count_d;
      ins_q       <= ins_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        op_q <= in_op;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
    if (in_acc) begin
      key_x_q <= s_axis_tdata[7:0];
      key_y_q <= s_axis_tdata[15:8];
      key_z_q <= s_axis_tdata[23:16];
      push_q  <= s_axis_tdata[49:34];
      tag_q   <= s_axis_tdata[65:50];
    end
  end

  assign s_axis_tready = (state_q == vdt_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {out_q.bad_index, out_q.table_full, out_q.found};
  assign m_axis_tdata  = {out_q.point_count, out_q.rd_tag, out_q.rd_rate, out_q.rd_spin,
                          out_q.rd_z, out_q.rd_y, out_q.rd_x, out_q.point_index};

endmodule

[rtl/vdt_checker.sv]
`include "vertex_dedup_table_with_decay_assert.svh"

module vdt_checker #(
  parameter int unsigned CAPACITY = vdt_pkg::CAPACITY_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic [71:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [2:0]  m_axis_tuser,
  input logic [79:0] m_axis_tdata
);

  // A stalled result beat keeps its contents.
  `VDT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

  // Every item leaves the idle state, so ready drops after an accepted beat.
  `VDT_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input accepted on back-to-back cycles")

  // Hit, full and bad index exclude each other.
  `VDT_ASSERT(a_flags_excl, m_axis_tvalid |-> $onehot0(m_axis_tuser), "more than one result flag set")

  // A full table gives only the count.
  `VDT_ASSERT(a_full_clean, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[68:0] == '0 && m_axis_tdata[79:69] >= 11'(CAPACITY), "table full result carries point data")

  // The count never passes the capacity.
  `VDT_ASSERT_ALWAYS(a_count_cap, m_axis_tvalid |-> m_axis_tdata[79:69] <= CAPACITY, "point count above capacity")

endmodule

bind vertex_dedup_table_with_decay vdt_checker #(.CAPACITY(CAPACITY)) u_vdt_checker (.*);

[tb/sv/vertex_dedup_table_with_decay_tb.sv]
module vertex_dedup_table_with_decay_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A shallow table keeps the full-table cases reachable in a short run.
  localparam int unsigned TABLE_DEPTH  = 32;
  localparam int unsigned RANDOM_ITEMS = 555;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [2:0]  OP_NONE      = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  key_x;
    logic [7:0]  key_y;
    logic [7:0]  key_z;
    logic [9:0]  point_sel;
    logic [15:0] push_req;
    logic [15:0] tag_value;
  } point_cmd_t;

  typedef struct packed {
    logic [9:0]  point_index;
    logic        found;
    logic        table_full;
    logic        bad_index;
    logic [7:0]  rd_x;
    logic [7:0]  rd_y;
    logic [7:0]  rd_z;
    logic [10:0] rd_spin;
    logic [7:0]  rd_rate;
    logic [15:0] rd_tag;
    logic [10:0] point_count;
  } point_reply_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [2:0]  m_axis_tuser;
  logic [79:0] m_axis_tdata;

  point_cmd_t   drv_cmd = '0;
  point_cmd_t   point_cmds[$];
  point_reply_t predicted_replies[$];

  // Keys the stimulus expects to be in the table, oldest first.
  logic [23:0]  gen_keys[$];

  // Shadow of the point table.
  logic [23:0]        mdl_key [TABLE_DEPTH];
  logic [10:0]        mdl_spin[TABLE_DEPTH];
  logic signed [7:0]  mdl_rate[TABLE_DEPTH];
  logic [15:0]        mdl_tag [TABLE_DEPTH];
  int unsigned        mdl_count;

  int unsigned cmds_queued;
  int unsigned cmds_taken;
  int unsigned replies_seen;
  bit          fail_seen;
  bit          in_taken;
  bit          out_taken;
  bit          rx_hold;
  bit          tx_calm;
  bit          rx_calm;
  int unsigned tx_gap;
  int unsigned rx_stall;

  assign s_axis_tuser = drv_cmd.op;
  assign s_axis_tdata = {6'd0, drv_cmd.tag_value, drv_cmd.push_req, drv_cmd.point_sel,
                         drv_cmd.key_z, drv_cmd.key_y, drv_cmd.key_x};

  vertex_dedup_table_with_decay #(
    .CAPACITY(TABLE_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic point_reply_t point_view(int unsigned idx);
    point_reply_t r;
    r = '0;
    r.point_index = 10'(idx);
    {r.rd_x, r.rd_y, r.rd_z} = mdl_key[idx];
    r.rd_spin = mdl_spin[idx];
    r.rd_rate = mdl_rate[idx];
    r.rd_tag  = mdl_tag[idx];
    return r;
  endfunction

  function automatic point_reply_t model_point_op(point_cmd_t c);
    point_reply_t r;
    logic [23:0]  key;
    int unsigned  i;
    int unsigned  at;
    bit           hit;
    int           sum;
    r   = '0;
    key = {c.key_x, c.key_y, c.key_z};
    hit = 1'b0;
    at  = 0;
    case (c.op)
      vdt_pkg::OP_FIND: begin
        // Newest entry first, so the highest matching index wins.
        for (i = mdl_count; i > 0; i--) begin
          if (!hit && mdl_key[i-1] == key) begin
            hit = 1'b1;
            at  = i - 1;
          end
        end
        if (hit) begin
          r = point_view(at);
          r.found = 1'b1;
        end else if (mdl_count >= TABLE_DEPTH) begin
          r.table_full = 1'b1;
        end else begin
          at = mdl_count;
          mdl_count++;
          mdl_key[at]  = key;
          mdl_spin[at] = '0;
          mdl_rate[at] = '0;
          r = point_view(at);
        end
      end
      vdt_pkg::OP_TICK: begin
        for (i = 0; i < mdl_count; i++) begin
          sum = int'(mdl_spin[i]) + int'(mdl_rate[i]);
          mdl_spin[i] = 11'(sum);
          if (mdl_rate[i] > 0) begin
            mdl_rate[i] = mdl_rate[i] - 8'sd1;
          end else if (mdl_rate[i] < 0) begin
            mdl_rate[i] = mdl_rate[i] + 8'sd1;
          end
        end
      end
      vdt_pkg::OP_KICK, vdt_pkg::OP_SET_TAG, vdt_pkg::OP_READ: begin
        if (c.point_sel >= mdl_count) begin
          r.point_index = c.point_sel;
          r.bad_index   = 1'b1;
        end else begin
          if (c.op == vdt_pkg::OP_KICK) begin
            sum = int'(mdl_rate[c.point_sel]) + int'($signed(c.push_req));
            if (sum > vdt_pkg::RATE_LIMIT) sum = vdt_pkg::RATE_LIMIT;
            if (sum < -vdt_pkg::RATE_LIMIT) sum = -vdt_pkg::RATE_LIMIT;
            mdl_rate[c.point_sel] = 8'(sum);
          end else if (c.op == vdt_pkg::OP_SET_TAG) begin
            mdl_tag[c.point_sel] = c.tag_value;
          end
          r = point_view(c.point_sel);
        end
      end
      vdt_pkg::OP_CLEAR_TAGS: begin
        // Entries past the count keep their tags.
        for (i = 0; i < mdl_count; i++) mdl_tag[i] = '0;
      end
      vdt_pkg::OP_EMPTY: begin
        mdl_count = 0;
      end
      default: begin
      end
    endcase
    r.point_count = 11'(mdl_count);
    return r;
  endfunction

  function automatic point_cmd_t random_cmd();
    point_cmd_t c;
    c.op        = 3'($urandom);
    c.key_x     = 8'($urandom);
    c.key_y     = 8'($urandom);
    c.key_z     = 8'($urandom);
    c.point_sel = 10'($urandom);
    c.push_req  = 16'($urandom);
    c.tag_value = 16'($urandom);
    return c;
  endfunction

  // Fields an op does not use carry random content.
  task automatic queue_op(input logic [2:0] op, input logic [23:0] key,
                          input logic [9:0] sel, input logic [15:0] val);
    point_cmd_t  c;
    bit          known;
    int unsigned i;
    c  = random_cmd();
    c.op = op;
    known = 1'b0;
    case (op)
      vdt_pkg::OP_FIND: begin
        {c.key_x, c.key_y, c.key_z} = key;
        for (i = 0; i < gen_keys.size(); i++) begin
          if (gen_keys[i] == key) known = 1'b1;
        end
        if (!known && gen_keys.size() < TABLE_DEPTH) gen_keys.push_back(key);
      end
      vdt_pkg::OP_KICK: begin
        c.point_sel = sel;
        c.push_req  = val;
      end
      vdt_pkg::OP_SET_TAG: begin
        c.point_sel = sel;
        c.tag_value = val;
      end
      vdt_pkg::OP_READ:  c.point_sel = sel;
      vdt_pkg::OP_EMPTY: gen_keys.delete();
      default: begin
      end
    endcase
    point_cmds.push_back(c);
    cmds_queued++;
  endtask

  function automatic logic [9:0] pick_sel();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (gen_keys.size() != 0 && roll < 82) return 10'($urandom_range(0, gen_keys.size() - 1));
    if (roll < 90) return 10'(gen_keys.size());
    return 10'($urandom);
  endfunction

  function automatic logic [23:0] pick_key(int unsigned reuse_pct);
    if (gen_keys.size() != 0 && $urandom_range(0, 99) < reuse_pct) begin
      return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
    end
    return 24'($urandom);
  endfunction

  function automatic logic [15:0] pick_push();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 400)) - 200);
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      fail_seen = 1'b1;
      $display("%0t: reply %0d %s expected 0x%0h, got 0x%0h",
               $time, replies_seen, what, want, seen);
    end
  endtask

  // Sender: one draw of idle cycles per beat, with calm stretches of none.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (tx_gap != 0) begin
        tx_gap = tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (point_cmds.size() != 0) begin
        drv_cmd <= point_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 18);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls after each beat, and holds tready low throughout while rx_hold is set.
  always @(negedge clk_i) begin
    if (out_taken) begin
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      rx_stall = rx_calm ? 0 : $urandom_range(0, 18);
    end
    if (rx_hold || rx_stall != 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
    if (rx_stall != 0) rx_stall = rx_stall - 1;
  end

  always @(posedge clk_i) begin
    point_reply_t want;
    point_reply_t got;
    in_taken  <= s_axis_tvalid && s_axis_tready;
    out_taken <= m_axis_tvalid && m_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predicted_replies.push_back(model_point_op(drv_cmd));
      cmds_taken++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found       = m_axis_tuser[0];
      got.table_full  = m_axis_tuser[1];
      got.bad_index   = m_axis_tuser[2];
      got.point_index = m_axis_tdata[9:0];
      got.rd_x        = m_axis_tdata[17:10];
      got.rd_y        = m_axis_tdata[25:18];
      got.rd_z        = m_axis_tdata[33:26];
      got.rd_spin     = m_axis_tdata[44:34];
      got.rd_rate     = m_axis_tdata[52:45];
      got.rd_tag      = m_axis_tdata[68:53];
      got.point_count = m_axis_tdata[79:69];
      if (predicted_replies.size() == 0) begin
        fail_seen = 1'b1;
        $display("%0t: reply %0d expected none, got tuser 0x%0h tdata 0x%0h",
                 $time, replies_seen, m_axis_tuser, m_axis_tdata);
      end else begin
        want = predicted_replies.pop_front();
        check_field("point_index", want.point_index, got.point_index);
        check_field("found",       want.found,       got.found);
        check_field("table_full",  want.table_full,  got.table_full);
        check_field("bad_index",   want.bad_index,   got.bad_index);
        check_field("rd_x",        want.rd_x,        got.rd_x);
        check_field("rd_y",        want.rd_y,        got.rd_y);
        check_field("rd_z",        want.rd_z,        got.rd_z);
        check_field("rd_spin",     want.rd_spin,     got.rd_spin);
        check_field("rd_rate",     want.rd_rate,     got.rd_rate);
        check_field("rd_tag",      want.rd_tag,      got.rd_tag);
        check_field("point_count", want.point_count, got.point_count);
      end
      replies_seen++;
    end
  end

  // Long receiver hold-off partway through, so results back up into the input.
  initial begin
    while (cmds_taken < 150) @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #6_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned n_random;
    int unsigned ep_len;
    int unsigned roll;
    int unsigned j;
    int unsigned i;
    bit          filling;
    bit          ignored;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      mdl_key[i]  = '0;
      mdl_spin[i] = '0;
      mdl_rate[i] = '0;
      mdl_tag[i]  = '0;
    end
    mdl_count = 0;

    queue_op(vdt_pkg::OP_READ,       24'h000000, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_TICK,       24'h000000, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_FIND,       24'h000000, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_FIND,       24'hff80ff, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_FIND,       24'h000000, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_FIND,       24'hff7f00, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_KICK,       24'h000000, 10'd0,   16'h7fff);
    queue_op(vdt_pkg::OP_KICK,       24'h000000, 10'd1,   16'h8000);
    queue_op(vdt_pkg::OP_KICK,       24'h000000, 10'd2,   16'h0003);
    queue_op(vdt_pkg::OP_KICK,       24'h000000, 10'd2,   16'hfffb);
    queue_op(vdt_pkg::OP_TICK,       24'h000000, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_TICK,       24'h000000, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_SET_TAG,    24'h000000, 10'd1,   16'hffff);
    queue_op(vdt_pkg::OP_READ,       24'h000000, 10'd1,   16'h0000);
    queue_op(vdt_pkg::OP_KICK,       24'h000000, 10'd3,   16'h0010);
    queue_op(vdt_pkg::OP_SET_TAG,    24'h000000, 10'h3ff, 16'h1234);
    queue_op(vdt_pkg::OP_READ,       24'h000000, 10'h3ff, 16'h0000);
    queue_op(OP_NONE,                24'h000000, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_CLEAR_TAGS, 24'h000000, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_SET_TAG,    24'h000000, 10'd0,   16'ha5a5);
    // After emptying, clear_tags touches nothing and the insert keeps the old tag.
    queue_op(vdt_pkg::OP_EMPTY,      24'h000000, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_CLEAR_TAGS, 24'h000000, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_FIND,       24'h123456, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_FIND,       24'hff80ff, 10'd0,   16'h0000);
    queue_op(vdt_pkg::OP_READ,       24'h000000, 10'd0,   16'h0000);

    // Episodes: filling ones drive the table to full, mixed ones work on a
    // partly used table.
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      filling = ($urandom_range(0, 3) == 0);
      ep_len  = $urandom_range(15, 60);
      if ($urandom_range(0, 1) == 0) begin
        queue_op(vdt_pkg::OP_EMPTY, 24'h0, 10'd0, 16'h0);
        n_random++;
      end
      for (j = 0; j < ep_len && n_random < RANDOM_ITEMS; j++) begin
        roll    = $urandom_range(0, 99);
        ignored = 1'b0;
        if (roll < (filling ? 75 : 35)) begin
          queue_op(vdt_pkg::OP_FIND, pick_key(filling ? 15 : 55), 10'd0, 16'h0);
        end else if (roll < (filling ? 80 : 48)) begin
          queue_op(vdt_pkg::OP_TICK, 24'h0, 10'd0, 16'h0);
        end else if (roll < (filling ? 88 : 66)) begin
          queue_op(vdt_pkg::OP_KICK, 24'h0, pick_sel(), pick_push());
        end else if (roll < (filling ? 92 : 77)) begin
          queue_op(vdt_pkg::OP_SET_TAG, 24'h0, pick_sel(), 16'($urandom));
        end else if (roll < (filling ? 98 : 92)) begin
          queue_op(vdt_pkg::OP_READ, 24'h0, pick_sel(), 16'h0);
        end else if (roll < (filling ? 99 : 96)) begin
          queue_op(vdt_pkg::OP_CLEAR_TAGS, 24'h0, 10'd0, 16'h0);
        end else if (!filling && roll < 98) begin
          queue_op(vdt_pkg::OP_EMPTY, 24'h0, 10'd0, 16'h0);
        end else begin
          queue_op(OP_NONE, 24'h0, 10'd0, 16'h0);
          ignored = 1'b1;
        end
        if (!ignored) n_random++;
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_taken != cmds_queued || predicted_replies.size() != 0) @(negedge clk_i);
    repeat (2 * TABLE_DEPTH + 20) @(negedge clk_i);
    if (!fail_seen) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[vertex_dedup_table_with_decay.f]
+incdir+rtl
rtl/vdt_pkg.sv
rtl/vdt_mem.sv
rtl/vdt_alu.sv
rtl/vertex_dedup_table_with_decay.sv
rtl/vdt_checker.sv
tb/sv/vertex_dedup_table_with_decay_tb.sv
